// ----- hdl/set_assoc_cache_lru_model_defines.svh -----
// Assertion macros shared by the checker of the set-associative cache tag store.
`ifndef SET_ASSOC_CACHE_LRU_MODEL_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_MODEL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SACL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SACL_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sacl_pkg.sv -----
// Types, constants and helper functions of the set-associative cache tag store.
`default_nettype none

package sacl_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_SET_BITS_DEF = 8;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 32;

  // Fixed field widths.
  localparam int OP_W         = 2;
  localparam int OUTCOME_W    = 2;
  localparam int WAY_USED_W   = 3;
  localparam int SET_INDEX_W  = 8;
  localparam int CNT_W        = 32;
  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;

  // Register reset values.
  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = SET_BITS_W'(4);
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = BLOCK_BITS_W'(4);
  localparam logic [WAYS_W-1:0]       WAYS_RST       = WAYS_W'(1);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } op_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SECOND
  } state_t;

  // What one lookup decided for the selected set.
  typedef struct packed {
    outcome_t                outcome;
    logic [WAY_USED_W-1:0]   way_used;
  } lookup_res_t;

  // Bits needed to index n items (at least one).
  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Bits of one way in a set row: valid, recency rank, tag.
  function automatic int way_width(input int max_ways, input int addr_width);
    return 1 + idx_width(max_ways) + addr_width;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sacl_ifs.sv -----
// Request and result channel interfaces of the set-associative cache tag store.
`default_nettype none

interface sacl_in_if #(
  parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [sacl_pkg::OP_W-1:0]   operation;
  logic [ADDR_WIDTH-1:0]       address;

  modport source (output valid, operation, address, input ready);
  modport sink   (input valid, operation, address, output ready);
endinterface

interface sacl_out_if;
  logic                              valid;
  logic                              ready;
  logic [sacl_pkg::OUTCOME_W-1:0]    outcome;
  logic [sacl_pkg::WAY_USED_W-1:0]   way_used;
  logic [sacl_pkg::SET_INDEX_W-1:0]  set_index;
  logic [sacl_pkg::CNT_W-1:0]        hit_total;
  logic [sacl_pkg::CNT_W-1:0]        miss_total;
  logic [sacl_pkg::CNT_W-1:0]        eviction_total;
  logic                              last_of_item;

  modport source (output valid, outcome, way_used, set_index, hit_total, miss_total,
                  eviction_total, last_of_item, input ready);
  modport sink   (input valid, outcome, way_used, set_index, hit_total, miss_total,
                  eviction_total, last_of_item, output ready);
endinterface

`default_nettype wire

// ----- hdl/set_assoc_cache_lru_model.sv -----
// Top level of the set-associative cache tag store with true LRU replacement.
//
// Each request (load, store or modify of a byte address) reads the row of its set from one
// synchronous RAM that holds valid bit, recency rank and tag of every way, compares all ways in
// use at once, and writes the updated row back. A load or store reads the row, then compares
// and writes it back; a modify then makes a second, always-hitting access on the row it just
// wrote. A request is taken again the cycle after its last result enters the output register,
// even while that result still waits. A busy output stalls the write-back. After reset a
// clearing pass writes every one of the 2**MAX_SET_BITS rows (256 by default) before the
// first request is taken; configuration writes are taken at any time.
`default_nettype none

module set_assoc_cache_lru_model #(
  parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = sacl_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  sacl_in_if.sink                                  in_ch,
  sacl_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NUM_ROWS = 1 << MAX_SET_BITS;
  localparam int SET_W    = sacl_pkg::idx_width(NUM_ROWS);
  localparam int ROW_W    = MAX_WAYS * sacl_pkg::way_width(MAX_WAYS, ADDR_WIDTH);
  localparam int NW_W     = $clog2(MAX_WAYS + 1);

  logic [sacl_pkg::SET_BITS_W-1:0]   set_bits_r;
  logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits_r;
  logic [sacl_pkg::WAYS_W-1:0]       ways_r;
  logic [sacl_pkg::SET_BITS_W-1:0]   sb_eff;
  logic [NW_W-1:0]                   nw_eff;

  logic                  ram_we;
  logic                  ram_re;
  logic [SET_W-1:0]      ram_addr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [ROW_W-1:0]      ram_rdata;
  logic [ROW_W-1:0]      work_row;
  logic [ROW_W-1:0]      lk_row;
  logic [ADDR_WIDTH-1:0] work_tag;
  sacl_pkg::lookup_res_t lk_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= sacl_pkg::SET_BITS_RST;
      block_bits_r <= sacl_pkg::BLOCK_BITS_RST;
      ways_r       <= sacl_pkg::WAYS_RST;
    end else if (cfg_we) begin
      unique case (sacl_pkg::cfg_reg_t'(cfg_index))
        sacl_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_data[sacl_pkg::SET_BITS_W-1:0];
        sacl_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_data[sacl_pkg::BLOCK_BITS_W-1:0];
        sacl_pkg::CFG_WAYS:       ways_r       <= cfg_data[sacl_pkg::WAYS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp set bits and ways in use to what the storage holds.
  always_comb begin
    if (int'(set_bits_r) > MAX_SET_BITS) begin
      sb_eff = sacl_pkg::SET_BITS_W'(MAX_SET_BITS);
    end else begin
      sb_eff = set_bits_r;
    end
    if (ways_r == '0) begin
      nw_eff = NW_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      nw_eff = NW_W'(MAX_WAYS);
    end else begin
      nw_eff = NW_W'(ways_r);
    end
  end

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  sacl_lookup #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_lookup (
    .row_in  (work_row),
    .tag     (work_tag),
    .nw      (nw_eff),
    .row_out (lk_row),
    .res     (lk_res)
  );

  sacl_ctrl #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .sb        (sb_eff),
    .bb        (block_bits_r),
    .ram_rdata (ram_rdata),
    .lk_row    (lk_row),
    .lk_res    (lk_res),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .work_row  (work_row),
    .work_tag  (work_tag)
  );

endmodule

`default_nettype wire

// ----- hdl/sacl_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [sacl_pkg::idx_width(DEPTH)-1:0]     waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [sacl_pkg::idx_width(DEPTH)-1:0]     raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sacl_lookup.sv -----
// Tag compare, victim choice and LRU rank update of one set row.
`default_nettype none

module sacl_lookup #(
  parameter int MAX_WAYS   = sacl_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic [MAX_WAYS*sacl_pkg::way_width(MAX_WAYS, ADDR_WIDTH)-1:0] row_in,
  input  wire logic [ADDR_WIDTH-1:0]                                       tag,
  input  wire logic [$clog2(MAX_WAYS+1)-1:0]                               nw,
  output logic      [MAX_WAYS*sacl_pkg::way_width(MAX_WAYS, ADDR_WIDTH)-1:0] row_out,
  output sacl_pkg::lookup_res_t                                            res
);

  localparam int RANK_W = sacl_pkg::idx_width(MAX_WAYS);
  localparam int WIDX_W = sacl_pkg::idx_width(MAX_WAYS);
  localparam int WAY_W  = sacl_pkg::way_width(MAX_WAYS, ADDR_WIDTH);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0]   vld;
  logic [MAX_WAYS-1:0]   use_v;
  logic [MAX_WAYS-1:0]   hit_v;
  logic [MAX_WAYS-1:0]   free_v;
  logic [RANK_W-1:0]     rnk [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] tg  [MAX_WAYS];
  logic [MAX_WAYS-1:0]   nvld;
  logic [RANK_W-1:0]     nrnk [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] ntg  [MAX_WAYS];

  logic              hit;
  logic              have_free;
  logic [WIDX_W-1:0] hit_way;
  logic [WIDX_W-1:0] free_way;
  logic [WIDX_W-1:0] lru_way;
  logic [RANK_W-1:0] lru_rank;
  logic [WIDX_W-1:0] way_sel;
  logic [RANK_W-1:0] ref_rank;
  logic              age_all;

  // Unpack the row and compare all ways in parallel.
  for (genvar g = 0; g < MAX_WAYS; g++) begin : g_way
    assign vld[g]    = row_in[g*WAY_W];
    assign rnk[g]    = row_in[g*WAY_W+1 +: RANK_W];
    assign tg[g]     = row_in[g*WAY_W+1+RANK_W +: ADDR_WIDTH];
    assign use_v[g]  = (g < int'(nw));
    assign hit_v[g]  = use_v[g] && vld[g] && (tg[g] == tag);
    assign free_v[g] = use_v[g] && !vld[g];
    assign row_out[g*WAY_W +: WAY_W] = {ntg[g], nrnk[g], nvld[g]};
  end

  // Lowest-numbered hit and free ways; oldest way with ties to the lowest.
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_v[i]) begin
        hit_way = WIDX_W'(i);
      end
      if (free_v[i]) begin
        free_way = WIDX_W'(i);
      end
    end
    lru_way  = '0;
    lru_rank = rnk[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (use_v[i] && (rnk[i] > lru_rank)) begin
        lru_way  = WIDX_W'(i);
        lru_rank = rnk[i];
      end
    end
  end

  assign hit       = |hit_v;
  assign have_free = |free_v;
  assign way_sel   = hit ? hit_way : (have_free ? free_way : lru_way);
  assign ref_rank  = rnk[way_sel];
  // A fill into a free line ages every other valid way in use that is not already oldest.
  assign age_all   = !hit && have_free;

  // New row: selected way becomes most recent and takes the tag on a miss; younger ways age by one.
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      nvld[i] = vld[i];
      nrnk[i] = rnk[i];
      ntg[i]  = tg[i];
      if (way_sel == WIDX_W'(i)) begin
        nrnk[i] = '0;
        if (!hit) begin
          nvld[i] = 1'b1;
          ntg[i]  = tag;
        end
      end else if (use_v[i] && vld[i] && (age_all || (rnk[i] < ref_rank)) &&
                   (rnk[i] != RANK_MAX)) begin
        nrnk[i] = rnk[i] + RANK_W'(1);
      end
    end
  end

  // Outcome of this access.
  always_comb begin
    res.way_used = sacl_pkg::WAY_USED_W'(way_sel);
    if (hit) begin
      res.outcome = sacl_pkg::OUT_HIT;
    end else if (have_free) begin
      res.outcome = sacl_pkg::OUT_FILL;
    end else begin
      res.outcome = sacl_pkg::OUT_EVICT;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sacl_ctrl.sv -----
// Sequencer of the tag store: clearing pass, row read-modify-write, counters, result register.
`default_nettype none

module sacl_ctrl #(
  parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = sacl_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  sacl_in_if.sink                                         in_ch,
  sacl_out_if.source                                      out_ch,
  input  wire logic [sacl_pkg::SET_BITS_W-1:0]            sb,
  input  wire logic [sacl_pkg::BLOCK_BITS_W-1:0]          bb,
  input  wire logic [MAX_WAYS*sacl_pkg::way_width(MAX_WAYS, ADDR_WIDTH)-1:0] ram_rdata,
  input  wire logic [MAX_WAYS*sacl_pkg::way_width(MAX_WAYS, ADDR_WIDTH)-1:0] lk_row,
  input  wire sacl_pkg::lookup_res_t                      lk_res,
  output logic                                            ram_we,
  output logic                                            ram_re,
  output logic [sacl_pkg::idx_width(1 << MAX_SET_BITS)-1:0] ram_addr,
  output logic [MAX_WAYS*sacl_pkg::way_width(MAX_WAYS, ADDR_WIDTH)-1:0] ram_wdata,
  output logic [MAX_WAYS*sacl_pkg::way_width(MAX_WAYS, ADDR_WIDTH)-1:0] work_row,
  output logic [ADDR_WIDTH-1:0]                           work_tag
);

  localparam int NUM_ROWS = 1 << MAX_SET_BITS;
  localparam int SET_W    = sacl_pkg::idx_width(NUM_ROWS);
  localparam int ROW_W    = MAX_WAYS * sacl_pkg::way_width(MAX_WAYS, ADDR_WIDTH);
  localparam int CNT_W    = sacl_pkg::CNT_W;
  localparam logic [SET_W-1:0] CLR_LAST = SET_W'(NUM_ROWS - 1);

  sacl_pkg::state_t state_r, state_nxt;

  logic [SET_W-1:0]      clr_idx_r;
  logic [SET_W-1:0]      set_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic                  modify_r;
  logic [ROW_W-1:0]      row_r;
  logic [CNT_W-1:0]      hit_r, hit_nxt;
  logic [CNT_W-1:0]      miss_r, miss_nxt;
  logic [CNT_W-1:0]      evict_r, evict_nxt;

  logic                           out_valid_r;
  sacl_pkg::outcome_t             out_outcome_r;
  logic [sacl_pkg::WAY_USED_W-1:0]  out_way_r;
  logic [sacl_pkg::SET_INDEX_W-1:0] out_set_r;
  logic                           out_last_r;

  logic                  in_fire;
  logic                  op_ok;
  logic                  can_ld;
  logic                  ld;
  logic                  in_ready;
  logic                  use_row_r;
  logic                  clearing;
  logic [ADDR_WIDTH-1:0] addr_shift;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_in;
  logic [5:0]            tag_shamt;
  logic [ADDR_WIDTH-1:0] tag_in;

  // Split the request address into set index and tag.
  assign addr_shift = in_ch.address >> bb;
  assign set_mask   = ~({SET_W{1'b1}} << sb);
  assign set_in     = addr_shift[SET_W-1:0] & set_mask;
  assign tag_shamt  = {2'b00, sb} + {1'b0, bb};
  assign tag_in     = in_ch.address >> tag_shamt;

  // Only load, store and modify start an access; other codes are dropped.
  always_comb begin
    unique case (sacl_pkg::op_t'(in_ch.operation)) inside
      sacl_pkg::OP_LOAD, sacl_pkg::OP_STORE, sacl_pkg::OP_MODIFY: op_ok = 1'b1;
      default: op_ok = 1'b0;
    endcase
  end

  assign in_fire = in_ch.valid && in_ready;
  assign can_ld  = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sacl_pkg::ST_CLEAR: begin
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_IDLE: begin
        if (in_fire && op_ok) begin
          state_nxt = sacl_pkg::ST_ACCESS;
        end
      end
      sacl_pkg::ST_ACCESS: begin
        if (can_ld) begin
          state_nxt = modify_r ? sacl_pkg::ST_SECOND : sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_SECOND: begin
        if (can_ld) begin
          state_nxt = sacl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sacl_pkg::ST_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ld        = 1'b0;
    use_row_r = 1'b0;
    clearing  = 1'b0;
    ram_addr  = set_r;
    unique case (state_r)
      sacl_pkg::ST_CLEAR: begin
        clearing = 1'b1;
        ram_addr = clr_idx_r;
      end
      sacl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ram_re   = in_ch.valid;
        ram_addr = set_in;
      end
      sacl_pkg::ST_ACCESS: begin
        ld = can_ld;
      end
      sacl_pkg::ST_SECOND: begin
        ld        = can_ld;
        use_row_r = 1'b1;
      end
      default: begin
        clearing = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = in_ready;
  assign ram_we      = clearing || ld;
  assign ram_wdata   = clearing ? '0 : lk_row;
  assign work_row    = use_row_r ? row_r : ram_rdata;
  assign work_tag    = tag_r;

  // Saturating counters after this access.
  always_comb begin
    hit_nxt   = hit_r;
    miss_nxt  = miss_r;
    evict_nxt = evict_r;
    if (lk_res.outcome == sacl_pkg::OUT_HIT) begin
      if (hit_r != sacl_pkg::CNT_MAX) begin
        hit_nxt = hit_r + CNT_W'(1);
      end
    end else begin
      if (miss_r != sacl_pkg::CNT_MAX) begin
        miss_nxt = miss_r + CNT_W'(1);
      end
      if ((lk_res.outcome == sacl_pkg::OUT_EVICT) && (evict_r != sacl_pkg::CNT_MAX)) begin
        evict_nxt = evict_r + CNT_W'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sacl_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      hit_r       <= '0;
      miss_r      <= '0;
      evict_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_idx_r <= clr_idx_r + SET_W'(1);
      end
      if (ld) begin
        hit_r       <= hit_nxt;
        miss_r      <= miss_nxt;
        evict_r     <= evict_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request fields, updated row and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      set_r    <= set_in;
      tag_r    <= tag_in;
      modify_r <= (sacl_pkg::op_t'(in_ch.operation) == sacl_pkg::OP_MODIFY);
    end
    if (ld) begin
      row_r         <= lk_row;
      out_outcome_r <= lk_res.outcome;
      out_way_r     <= lk_res.way_used;
      out_set_r     <= sacl_pkg::SET_INDEX_W'(set_r);
      out_last_r    <= use_row_r || !modify_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.outcome        = out_outcome_r;
  assign out_ch.way_used       = out_way_r;
  assign out_ch.set_index      = out_set_r;
  assign out_ch.hit_total      = hit_r;
  assign out_ch.miss_total     = miss_r;
  assign out_ch.eviction_total = evict_r;
  assign out_ch.last_of_item   = out_last_r;

endmodule

`default_nettype wire

// ----- hdl/sacl_checker.sv -----
// Port-level checks of the set-associative cache tag store, bound to its top level.
`default_nettype none
`include "set_assoc_cache_lru_model_defines.svh"

module sacl_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic [sacl_pkg::OP_W-1:0]          in_operation,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [sacl_pkg::OUTCOME_W-1:0]     out_outcome,
  input wire logic [sacl_pkg::CNT_W-1:0]         out_miss_total,
  input wire logic [sacl_pkg::CNT_W-1:0]         out_eviction_total
);

  logic req_known;
  logic req_taken;
  logic miss_result;
  logic counts_ok;

  // Only load, store and modify start a row access.
  assign req_known   = (in_operation == sacl_pkg::OP_LOAD) ||
                       (in_operation == sacl_pkg::OP_STORE) ||
                       (in_operation == sacl_pkg::OP_MODIFY);
  assign req_taken   = in_valid && in_ready && req_known;

  // A miss result must already be reflected in the running totals.
  assign miss_result = out_valid && (out_outcome != sacl_pkg::OUT_HIT);
  assign counts_ok   = (out_miss_total != '0) &&
                       ((out_outcome != sacl_pkg::OUT_EVICT) || (out_eviction_total != '0));

  // A pending result is held until it is taken.
  `SACL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // Reset empties the result register.
  `SACL_ASSERT_ALWAYS_NEXT(a_rst_empty, !rst_n, !out_valid, "result present after reset")

  // A started access keeps the block busy in the cycle after it is taken.
  `SACL_ASSERT_NEXT(a_busy_after_req, req_taken, !in_ready, "request taken during row access")

  // A miss result is always counted.
  `SACL_ASSERT_NOW(a_miss_counted, miss_result, counts_ok, "miss or eviction not counted")

endmodule

bind set_assoc_cache_lru_model sacl_checker u_sacl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_operation       (in_ch.operation),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_outcome        (out_ch.outcome),
  .out_miss_total     (out_ch.miss_total),
  .out_eviction_total (out_ch.eviction_total)
);

`default_nettype wire

// ----- tb/set_assoc_cache_lru_model_test.sv -----
// Self-checking testbench for the set-associative cache tag store with LRU replacement.
`timescale 1ns / 100ps

module set_assoc_cache_lru_model_test;

  localparam int MAX_SET_BITS  = sacl_pkg::MAX_SET_BITS_DEF;
  localparam int MAX_WAYS      = sacl_pkg::MAX_WAYS_DEF;
  localparam int NUM_LINES     = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 104;
  localparam int CW            = sacl_pkg::CNT_W;
  localparam int DW            = sacl_pkg::CFG_DATA_W;
  localparam logic [sacl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    sacl_pkg::outcome_t                outcome;
    logic [sacl_pkg::WAY_USED_W-1:0]   way_used;
    logic [sacl_pkg::SET_INDEX_W-1:0]  set_index;
    logic [CW-1:0]                     hit_total;
    logic [CW-1:0]                     miss_total;
    logic [CW-1:0]                     eviction_total;
    logic                              last_of_item;
  } cache_result_t;

  typedef enum bit {ROW_REQUEST, ROW_CONFIG} row_kind_t;

  // One line of the directed plan: a request, optionally with its first result typed in,
  // or a register write.
  typedef struct {
    row_kind_t                         kind;
    logic [sacl_pkg::OP_W-1:0]         op;
    logic [31:0]                       addr;
    bit                                typed;
    sacl_pkg::outcome_t                outcome;
    logic [sacl_pkg::WAY_USED_W-1:0]   way;
    logic [sacl_pkg::SET_INDEX_W-1:0]  set_idx;
    sacl_pkg::cfg_reg_t                cfg_sel;
    logic [DW-1:0]                     cfg_value;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [DW-1:0]                  cfg_data;

  sacl_in_if  in_ch ();
  sacl_out_if out_ch ();

  set_assoc_cache_lru_model DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the tag store and its configuration.
  bit                                  line_valid [NUM_LINES];
  logic [63:0]                         line_tag   [NUM_LINES];
  logic [2:0]                          line_rank  [NUM_LINES];
  logic [CW-1:0]                       hits, misses, evictions;
  logic [sacl_pkg::SET_BITS_W-1:0]     set_bits_cur;
  logic [sacl_pkg::BLOCK_BITS_W-1:0]   block_bits_cur;
  logic [sacl_pkg::WAYS_W-1:0]         ways_cur;

  cache_result_t pending_results [$];
  plan_row_t     plan [$];
  int  failures;
  int  requests_sent;
  int  results_seen;
  bit  src_calm;
  bit  snk_calm;

  function automatic logic [CW-1:0] saturating_inc(logic [CW-1:0] c);
    return (c == sacl_pkg::CNT_MAX) ? c : c + CW'(1);
  endfunction

  // Set bits in use, limited to what the store holds.
  function automatic int unsigned eff_set_bits();
    return (32'(set_bits_cur) > 32'(MAX_SET_BITS)) ? 32'(MAX_SET_BITS) : 32'(set_bits_cur);
  endfunction

  // Ways in use: zero counts as one, and no more than the store holds.
  function automatic int unsigned eff_ways();
    if (ways_cur == '0) return 1;
    return (32'(ways_cur) > 32'(MAX_WAYS)) ? 32'(MAX_WAYS) : 32'(ways_cur);
  endfunction

  // Make one way most recent; valid ways ranked below older_than grow one step older.
  function automatic void promote_way(int unsigned base, int unsigned way, int unsigned nw,
                                      int unsigned older_than);
    for (int unsigned i = 0; i < nw; i++) begin
      if (i != way && line_valid[base + i] && 32'(line_rank[base + i]) < older_than &&
          32'(line_rank[base + i]) < 32'(MAX_WAYS - 1))
        line_rank[base + i] = line_rank[base + i] + 3'd1;
    end
    line_rank[base + way] = '0;
  endfunction

  // One lookup of the tag store: decides hit, fill or eviction and updates the shadow state.
  function automatic cache_result_t access_line(logic [31:0] addr, bit last);
    int unsigned sb, bb, nw, set_sel, base, way, free_way, victim;
    logic [63:0] tag;
    bit hit, have_free;
    cache_result_t r;
    sb = eff_set_bits();
    bb = 32'(block_bits_cur);
    nw = eff_ways();
    set_sel = 32'((64'(addr) >> bb) & ((64'd1 << sb) - 64'd1));
    tag = 64'(addr) >> (sb + bb);
    base = set_sel * MAX_WAYS;
    hit = 1'b0;
    have_free = 1'b0;
    way = 0;
    free_way = 0;
    for (int unsigned i = 0; i < nw; i++) begin
      if (line_valid[base + i]) begin
        if (line_tag[base + i] == tag) begin
          hit = 1'b1;
          way = i;
          break;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_way = i;
      end
    end

    if (hit) begin
      hits = saturating_inc(hits);
      promote_way(base, way, nw, 32'(line_rank[base + way]));
      r.outcome = sacl_pkg::OUT_HIT;
    end else if (have_free) begin
      misses = saturating_inc(misses);
      way = free_way;
      line_valid[base + way] = 1'b1;
      line_tag[base + way] = tag;
      promote_way(base, way, nw, MAX_WAYS);
      r.outcome = sacl_pkg::OUT_FILL;
    end else begin
      misses = saturating_inc(misses);
      evictions = saturating_inc(evictions);
      // Oldest way wins; on equal ranks the lowest way is taken.
      victim = 0;
      for (int unsigned i = 1; i < nw; i++)
        if (line_rank[base + i] > line_rank[base + victim]) victim = i;
      way = victim;
      line_tag[base + way] = tag;
      promote_way(base, way, nw, 32'(line_rank[base + way]));
      r.outcome = sacl_pkg::OUT_EVICT;
    end

    r.way_used       = way[sacl_pkg::WAY_USED_W-1:0];
    r.set_index      = set_sel[sacl_pkg::SET_INDEX_W-1:0];
    r.hit_total      = hits;
    r.miss_total     = misses;
    r.eviction_total = evictions;
    r.last_of_item   = last;
    return r;
  endfunction

  function automatic plan_row_t request_row(logic [sacl_pkg::OP_W-1:0] op, logic [31:0] addr);
    plan_row_t row;
    row = '{kind: ROW_REQUEST, op: op, addr: addr, typed: 1'b0, outcome: sacl_pkg::OUT_HIT,
            way: '0, set_idx: '0, cfg_sel: sacl_pkg::CFG_SET_BITS, cfg_value: '0};
    return row;
  endfunction

  function automatic plan_row_t checked_row(logic [sacl_pkg::OP_W-1:0] op, logic [31:0] addr,
                                            sacl_pkg::outcome_t outcome, int way,
                                            int set_idx);
    plan_row_t row;
    row = request_row(op, addr);
    row.typed = 1'b1;
    row.outcome = outcome;
    row.way = way[sacl_pkg::WAY_USED_W-1:0];
    row.set_idx = set_idx[sacl_pkg::SET_INDEX_W-1:0];
    return row;
  endfunction

  function automatic plan_row_t config_row(sacl_pkg::cfg_reg_t sel, logic [DW-1:0] value);
    plan_row_t row;
    row = request_row(sacl_pkg::OP_LOAD, '0);
    row.kind = ROW_CONFIG;
    row.cfg_sel = sel;
    row.cfg_value = value;
    return row;
  endfunction

  // Offer one request after a random gap, then predict its results once it is accepted.
  // When typed, the first result's outcome, way and set come from the plan instead.
  task automatic send_request(logic [sacl_pkg::OP_W-1:0] op, logic [31:0] addr, bit typed,
                              sacl_pkg::outcome_t outcome,
                              logic [sacl_pkg::WAY_USED_W-1:0] way,
                              logic [sacl_pkg::SET_INDEX_W-1:0] set_idx);
    int gap, n;
    cache_result_t res;
    if (requests_sent % 40 == 0) src_calm = ($urandom_range(0, 2) == 0);
    requests_sent++;
    gap = src_calm ? 0 : int'($urandom_range(0, 19));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.address   <= addr;
    do @(posedge clk); while (!in_ch.ready);

    n = (op == sacl_pkg::OP_MODIFY) ? 2 : ((op == OP_UNUSED) ? 0 : 1);
    for (int k = 0; k < n; k++) begin
      res = access_line(addr, k == n - 1);
      if (k == 0 && typed) begin
        res.outcome   = outcome;
        res.way_used  = way;
        res.set_index = set_idx;
      end
      pending_results.push_back(res);
    end
  endtask

  // Stop offering requests and wait until every predicted result has come back.
  task automatic wait_until_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(sacl_pkg::cfg_reg_t sel, logic [DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      sacl_pkg::CFG_SET_BITS:   set_bits_cur   = value[sacl_pkg::SET_BITS_W-1:0];
      sacl_pkg::CFG_BLOCK_BITS: block_bits_cur = value[sacl_pkg::BLOCK_BITS_W-1:0];
      sacl_pkg::CFG_WAYS:       ways_cur       = value[sacl_pkg::WAYS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One random phase: a fresh configuration, then accesses drawn mostly from a small pool
  // of blocks crowded into a few sets, so that hits and evictions both come often.
  task automatic run_phase(logic [DW-1:0] sb_val, logic [DW-1:0] bb_val,
                           logic [DW-1:0] ways_val, int count);
    logic [31:0] pool [20];
    logic [31:0] set_choice [3];
    logic [31:0] setmask, offmask, addr;
    logic [sacl_pkg::OP_W-1:0] op;
    int unsigned sb, nw;
    int pool_size, n_sets, done, r;
    wait_until_idle();
    write_register(sacl_pkg::CFG_SET_BITS, sb_val);
    write_register(sacl_pkg::CFG_BLOCK_BITS, bb_val);
    write_register(sacl_pkg::CFG_WAYS, ways_val);

    sb = eff_set_bits();
    nw = eff_ways();
    offmask = 32'((64'd1 << block_bits_cur) - 64'd1);
    setmask = 32'(((64'd1 << sb) - 64'd1) << block_bits_cur);
    n_sets = int'($urandom_range(1, 3));
    for (int j = 0; j < n_sets; j++) set_choice[j] = $urandom() & setmask;
    pool_size = int'($urandom_range(2, 2 * nw + 4));
    for (int j = 0; j < pool_size; j++)
      pool[j] = ($urandom() & ~setmask & ~offmask) | set_choice[$urandom_range(0, n_sets - 1)];

    done = 0;
    while (done < count) begin
      r = int'($urandom_range(0, 99));
      if (r < 4) begin
        op = OP_UNUSED;
        addr = $urandom();
      end else begin
        op = sacl_pkg::OP_W'($urandom_range(0, 2));
        if (r < 14) addr = $urandom();
        else addr = pool[$urandom_range(0, pool_size - 1)] | ($urandom() & offmask);
        done++;
      end
      send_request(op, addr, 1'b0, sacl_pkg::OUT_HIT, '0, '0);
      // Now and then let the block run dry in the middle of a phase.
      if ($urandom_range(0, 59) == 0) wait_until_idle();
    end
  endtask

  task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stalls, then compare each result with the oldest prediction.
  initial begin
    cache_result_t want;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (results_seen % 40 == 0) snk_calm = ($urandom_range(0, 2) == 0);
      stall = snk_calm ? 0 : int'($urandom_range(0, 19));
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("outcome", CW'(want.outcome), CW'(out_ch.outcome));
        check_field("way_used", CW'(want.way_used), CW'(out_ch.way_used));
        check_field("set_index", CW'(want.set_index), CW'(out_ch.set_index));
        check_field("hit_total", want.hit_total, out_ch.hit_total);
        check_field("miss_total", want.miss_total, out_ch.miss_total);
        check_field("eviction_total", want.eviction_total, out_ch.eviction_total);
        check_field("last_of_item", CW'(want.last_of_item), CW'(out_ch.last_of_item));
      end
    end
  end

  // Request side: reset, directed plan, then random phases.
  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= sacl_pkg::CFG_SET_BITS;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= sacl_pkg::OP_LOAD;
    in_ch.address   <= '0;
    failures = 0;
    requests_sent = 0;
    results_seen = 0;
    for (int i = 0; i < NUM_LINES; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_rank[i]  = '0;
    end
    hits = '0;
    misses = '0;
    evictions = '0;
    set_bits_cur   = sacl_pkg::SET_BITS_RST;
    block_bits_cur = sacl_pkg::BLOCK_BITS_RST;
    ways_cur       = sacl_pkg::WAYS_RST;

    plan = '{
      // Reset configuration: one way, sixteen sets of sixteen-byte blocks.
      checked_row(sacl_pkg::OP_LOAD,   32'h0000_0000, sacl_pkg::OUT_FILL,  0, 0),
      checked_row(sacl_pkg::OP_LOAD,   32'h0000_000F, sacl_pkg::OUT_HIT,   0, 0),
      checked_row(sacl_pkg::OP_STORE,  32'h0000_0100, sacl_pkg::OUT_EVICT, 0, 0),
      checked_row(sacl_pkg::OP_MODIFY, 32'hFFFF_FFFF, sacl_pkg::OUT_FILL,  0, 15),
      // The unused operation code must leave the store untouched.
      request_row(OP_UNUSED, 32'h0000_0000),
      checked_row(sacl_pkg::OP_LOAD,   32'h0000_0108, sacl_pkg::OUT_HIT,   0, 0),
      // Eight ways: fill set zero, refresh way zero, then evict the least recent way.
      config_row(sacl_pkg::CFG_WAYS, 5'd8),
      checked_row(sacl_pkg::OP_LOAD,   32'h0000_0200, sacl_pkg::OUT_FILL,  1, 0),
      checked_row(sacl_pkg::OP_STORE,  32'h0000_0300, sacl_pkg::OUT_FILL,  2, 0),
      checked_row(sacl_pkg::OP_MODIFY, 32'h0000_0400, sacl_pkg::OUT_FILL,  3, 0),
      checked_row(sacl_pkg::OP_LOAD,   32'h0000_0500, sacl_pkg::OUT_FILL,  4, 0),
      checked_row(sacl_pkg::OP_STORE,  32'h0000_0600, sacl_pkg::OUT_FILL,  5, 0),
      checked_row(sacl_pkg::OP_LOAD,   32'h0000_0700, sacl_pkg::OUT_FILL,  6, 0),
      checked_row(sacl_pkg::OP_LOAD,   32'h0000_0800, sacl_pkg::OUT_FILL,  7, 0),
      checked_row(sacl_pkg::OP_LOAD,   32'h0000_0100, sacl_pkg::OUT_HIT,   0, 0),
      checked_row(sacl_pkg::OP_LOAD,   32'h0000_0900, sacl_pkg::OUT_EVICT, 1, 0),
      // Zero ways acts as one; oversized set and block fields push the tag off the top.
      config_row(sacl_pkg::CFG_WAYS, 5'd0),
      config_row(sacl_pkg::CFG_SET_BITS, 5'd15),
      config_row(sacl_pkg::CFG_BLOCK_BITS, 5'd31),
      checked_row(sacl_pkg::OP_LOAD,   32'h8000_0000, sacl_pkg::OUT_FILL,  0, 1),
      checked_row(sacl_pkg::OP_LOAD,   32'h7FFF_FFFF, sacl_pkg::OUT_EVICT, 0, 0),
      // Fully associative over eight ways, byte-sized blocks.
      config_row(sacl_pkg::CFG_WAYS, 5'd15),
      config_row(sacl_pkg::CFG_SET_BITS, 5'd0),
      config_row(sacl_pkg::CFG_BLOCK_BITS, 5'd0),
      checked_row(sacl_pkg::OP_LOAD,   32'h0000_0000, sacl_pkg::OUT_HIT,   0, 0),
      request_row(sacl_pkg::OP_MODIFY, 32'hFFFF_FFFF),
      request_row(sacl_pkg::OP_STORE,  32'h1234_5678),
      // Widest set field at the top of the address.
      config_row(sacl_pkg::CFG_SET_BITS, 5'd8),
      config_row(sacl_pkg::CFG_BLOCK_BITS, 5'd24),
      checked_row(sacl_pkg::OP_LOAD,   32'hAB00_0000, sacl_pkg::OUT_FILL,  0, 8'hAB),
      request_row(sacl_pkg::OP_STORE,  32'hABFF_FFFF)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG) begin
        wait_until_idle();
        write_register(plan[i].cfg_sel, plan[i].cfg_value);
      end else begin
        send_request(plan[i].op, plan[i].addr, plan[i].typed, plan[i].outcome, plan[i].way,
                     plan[i].set_idx);
      end
    end

    run_phase(5'd4, 5'd4, 5'd1, PHASE_ITEMS);
    run_phase(5'd1, 5'd6, 5'd2, PHASE_ITEMS);
    run_phase(5'd0, 5'd0, 5'd8, PHASE_ITEMS);
    run_phase(5'd15, 5'd31, 5'd15, PHASE_ITEMS);
    run_phase(5'd8, 5'd24, 5'd0, PHASE_ITEMS);
    run_phase(5'd3, 5'd5, 5'd4, PHASE_ITEMS);
    run_phase(DW'($urandom_range(0, 15)), DW'($urandom_range(0, 31)),
              DW'($urandom_range(0, 15)), PHASE_ITEMS);
    run_phase(DW'($urandom_range(0, 15)), DW'($urandom_range(0, 31)),
              DW'($urandom_range(0, 15)), PHASE_ITEMS);

    wait_until_idle();
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- set_assoc_cache_lru_model.f -----
+incdir+hdl
hdl/sacl_pkg.sv
hdl/sacl_ifs.sv
hdl/sacl_ram.sv
hdl/sacl_lookup.sv
hdl/sacl_ctrl.sv
hdl/set_assoc_cache_lru_model.sv
hdl/sacl_checker.sv
tb/set_assoc_cache_lru_model_test.sv
